@@ hw/rtl/rrmb_pkg.sv @@
package rrmb_pkg;

   localparam int MSG_KINDS_DEF = 8;
   localparam int MSG_KINDS_MAX = 32;

   localparam int ACTION_W   = 2;
   localparam int POST_ID_W  = 3;
   localparam int WORD_W     = 32;
   localparam int BYTE_W     = 8;
   localparam int MSG_KIND_W = 3;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_USER_W = 1;

   // request tdata field offsets
   localparam int REQ_POST_ID_LSB   = 0;
   localparam int REQ_POST_DATA_LSB = REQ_POST_ID_LSB + POST_ID_W;
   localparam int REQ_ACK_ID_LSB    = REQ_POST_DATA_LSB + WORD_W;
   localparam int REQ_ACK_SEQ_LSB   = REQ_ACK_ID_LSB + BYTE_W;
   localparam int REQ_FRAME_LSB     = REQ_ACK_SEQ_LSB + BYTE_W;
   localparam int REQ_USED_W        = REQ_FRAME_LSB + BYTE_W;

   localparam logic [BYTE_W-1:0] ACK_FRAME_LEN = 8'd2;

   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_POST    = 2'd0,
      ACT_REQUEST = 2'd1,
      ACT_ACK     = 2'd2
   } action_type;

   typedef struct packed {
      logic [WORD_W-1:0]     msg_word;
      logic [BYTE_W-1:0]     msg_seq;
      logic [MSG_KIND_W-1:0] msg_kind;
      logic                  msg_valid;
   } rsp_word_type;

endpackage

@@ hw/rtl/round_robin_acked_mailbox_core.sv @@
// channel  dir  tdata (low bit up)                                        tuser
// req      in   post_id 3, post_data 32, ack_id 8, ack_seq 8,             action 2
//               frame_length 8, zero pad to 64
// rsp      out  msg_valid 1, msg_kind 3, msg_seq 8, msg_word 32,          status 1
//               zero pad to 48
//
// one word per cycle sustained while rsp is not stalled; a word is held in the
// input register and its result, for a request or ack, is loaded into the output register
// the round-robin pick and mailbox update are one pass of logic between them
// reset clears pending bits, pointer, sequence, held message and both valids;
// stored data words are undefined until posted
// a stalled rsp holds a word in the input register, which drops req_tready
module round_robin_acked_mailbox_core #(
   parameter int MSG_KINDS = rrmb_pkg::MSG_KINDS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // post_id, post_data, ack_id, ack_seq, frame_length
   input  logic [rrmb_pkg::REQ_DATA_W-1:0] req_tdata,
   // action
   input  logic [rrmb_pkg::ACTION_W-1:0]   req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // msg_valid, msg_kind, msg_seq, msg_word
   output logic [rrmb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status
   output logic [rrmb_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import rrmb_pkg::*;

   localparam int KIND_W = (MSG_KINDS > 1) ? $clog2(MSG_KINDS) : 1;

   // input register
   logic                  in_valid_ff;
   action_type            in_action_ff;
   logic [POST_ID_W-1:0]  in_post_id_ff;
   logic [WORD_W-1:0]     in_post_data_ff;
   logic [BYTE_W-1:0]     in_ack_id_ff;
   logic [BYTE_W-1:0]     in_ack_seq_ff;
   logic [BYTE_W-1:0]     in_frame_ff;

   // mailbox state
   logic [MSG_KINDS-1:0]  pending_ff, pending_in;
   logic [WORD_W-1:0]     kind_words_ff [MSG_KINDS];
   logic [KIND_W-1:0]     pointer_ff, pointer_in;
   logic [BYTE_W-1:0]     next_seq_ff, next_seq_in;
   logic                  held_valid_ff, held_valid_in;
   logic [KIND_W-1:0]     held_kind_ff, held_kind_in;
   logic [BYTE_W-1:0]     held_seq_ff, held_seq_in;
   logic [WORD_W-1:0]     held_word_ff, held_word_in;

   // result register
   logic                  rsp_valid_ff;
   rsp_word_type          rsp_word_ff, rsp_word_in;
   logic                  rsp_status_ff, rsp_status_in;

   logic                  advance;
   logic                  produce;
   logic                  post_ok;
   logic [KIND_W-1:0]     post_idx;
   logic                  ack_ok;
   logic                  found;
   logic [KIND_W-1:0]     pick;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign post_ok  = int'(in_post_id_ff) < MSG_KINDS;
   assign post_idx = KIND_W'(in_post_id_ff);
   assign ack_ok   = (in_frame_ff == ACK_FRAME_LEN) && held_valid_ff
                     && (in_ack_id_ff == BYTE_W'(held_kind_ff))
                     && (in_ack_seq_ff == held_seq_ff);

   rrmb_arbiter #(
      .MSG_KINDS (MSG_KINDS),
      .KIND_W    (KIND_W)
   ) u_arbiter (
      .pending (pending_ff),
      .pointer (pointer_ff),
      .found   (found),
      .pick    (pick)
   );

   always_comb begin
      pending_in    = pending_ff;
      pointer_in    = pointer_ff;
      next_seq_in   = next_seq_ff;
      held_valid_in = held_valid_ff;
      held_kind_in  = held_kind_ff;
      held_seq_in   = held_seq_ff;
      held_word_in  = held_word_ff;
      rsp_status_in = STATUS_OK;
      produce       = 1'b0;
      case (in_action_ff)
         ACT_POST: begin
            if (post_ok) begin
               pending_in[post_idx] = 1'b1;
            end
         end
         ACT_REQUEST: begin
            produce = 1'b1;
            if (!held_valid_ff && found) begin
               pointer_in         = (int'(pick) == MSG_KINDS - 1) ? '0
                                    : KIND_W'(pick + 1'b1);
               pending_in[pick]   = 1'b0;
               held_valid_in      = 1'b1;
               held_kind_in       = pick;
               held_seq_in        = next_seq_ff;
               held_word_in       = kind_words_ff[pick];
               next_seq_in        = next_seq_ff + 8'd1;
            end
         end
         ACT_ACK: begin
            produce       = 1'b1;
            rsp_status_in = STATUS_REJECT;
            if (ack_ok) begin
               held_valid_in = 1'b0;
               held_kind_in  = '0;
               held_seq_in   = '0;
               held_word_in  = '0;
               rsp_status_in = STATUS_OK;
            end
         end
         default: begin
            produce = 1'b0;
         end
      endcase
      rsp_word_in.msg_valid = held_valid_in;
      rsp_word_in.msg_kind  = MSG_KIND_W'(held_kind_in);
      rsp_word_in.msg_seq   = held_seq_in;
      rsp_word_in.msg_word  = held_word_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pending_ff    <= '0;
         pointer_ff    <= '0;
         next_seq_ff   <= '0;
         held_valid_ff <= 1'b0;
         held_kind_ff  <= '0;
         held_seq_ff   <= '0;
         held_word_ff  <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            pending_ff    <= pending_in;
            pointer_ff    <= pointer_in;
            next_seq_ff   <= next_seq_in;
            held_valid_ff <= held_valid_in;
            held_kind_ff  <= held_kind_in;
            held_seq_ff   <= held_seq_in;
            held_word_ff  <= held_word_in;
         end
         if (advance && produce) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_action_ff    <= action_type'(req_tuser);
         in_post_id_ff   <= req_tdata[REQ_POST_ID_LSB +: POST_ID_W];
         in_post_data_ff <= req_tdata[REQ_POST_DATA_LSB +: WORD_W];
         in_ack_id_ff    <= req_tdata[REQ_ACK_ID_LSB +: BYTE_W];
         in_ack_seq_ff   <= req_tdata[REQ_ACK_SEQ_LSB +: BYTE_W];
         in_frame_ff     <= req_tdata[REQ_FRAME_LSB +: BYTE_W];
      end
      if (advance && produce) begin
         rsp_word_ff   <= rsp_word_in;
         rsp_status_ff <= rsp_status_in;
      end
      if (advance && (in_action_ff == ACT_POST) && post_ok) begin
         kind_words_ff[post_idx] <= in_post_data_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_word_ff);
   assign rsp_tuser  = rsp_status_ff;

   // a free mailbox shows an all-zero message
   assert property (@(posedge clock) disable iff (reset)
      !held_valid_ff |-> (held_kind_ff == '0) && (held_seq_ff == '0) && (held_word_ff == '0))
      else $error("free mailbox holds stale message fields");

   // taking a message stamps it and bumps the sequence once
   assert property (@(posedge clock) disable iff (reset)
      $rose(held_valid_ff) |-> next_seq_ff == BYTE_W'(held_seq_ff + 8'd1))
      else $error("sequence not advanced past held message");

   // the kind just taken is no longer pending
   assert property (@(posedge clock) disable iff (reset)
      $rose(held_valid_ff) |-> !pending_ff[held_kind_ff])
      else $error("picked kind still pending");

   // an empty result register never blocks the input side
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_tready)
      else $error("input stalled with empty result register");

endmodule

@@ hw/rtl/rrmb_arbiter.sv @@
module rrmb_arbiter #(
   parameter int MSG_KINDS = rrmb_pkg::MSG_KINDS_DEF,
   parameter int KIND_W    = (MSG_KINDS > 1) ? $clog2(MSG_KINDS) : 1
) (
   input  logic [MSG_KINDS-1:0] pending,
   input  logic [KIND_W-1:0]    pointer,
   output logic                 found,
   output logic [KIND_W-1:0]    pick
);
   import rrmb_pkg::*;

   logic [MSG_KINDS-1:0] upper;
   logic [MSG_KINDS-1:0] search;

   // kinds at or above the pointer take priority, else wrap to the lowest
   always_comb begin
      for (int i = 0; i < MSG_KINDS; i++) begin
         upper[i] = pending[i] && (i >= int'(pointer));
      end
      search = (|upper) ? upper : pending;
      pick   = '0;
      for (int i = MSG_KINDS - 1; i >= 0; i--) begin
         if (search[i]) begin
            pick = KIND_W'(i);
         end
      end
      found = |pending;
   end

endmodule
